FILE: hw/rtl/scalar_kalman_filter_top_defines.svh
// Assertion macros shared by the filter RTL.
// ASSERT_OFF removes every check at compile time.
`ifndef SCALAR_KALMAN_FILTER_TOP_DEFINES_SVH
`define SCALAR_KALMAN_FILTER_TOP_DEFINES_SVH

`ifndef ASSERT_OFF

// Consequent must hold in the same cycle as the antecedent.
`define SKF_ASSERT_IMPL(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define SKF_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`else

`define SKF_ASSERT_IMPL(lbl, clk_s, rst_s, ante, cons)
`define SKF_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons)

`endif

`endif

FILE: hw/rtl/skf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package skf_pkg;

  // Q16.16 word format
  localparam int DW = 32;
  localparam int FW = 16;

  // Divider works on the numerator magnitude shifted up by the fraction bits
  localparam int DIV_W     = DW + FW;
  localparam int DIV_CNT_W = $clog2(DIV_W);
  localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_W - 1);

  typedef logic signed [DW-1:0] fix_t;

  localparam fix_t FIX_MAX = {1'b0, {(DW-1){1'b1}}};
  localparam fix_t FIX_MIN = {1'b1, {(DW-1){1'b0}}};
  localparam fix_t FIX_ONE = fix_t'(DW'(1) << FW);

  // Register reset values
  localparam fix_t          STATE_GAIN_RST    = FIX_ONE;
  localparam fix_t          OBSERVE_GAIN_RST  = FIX_ONE;
  localparam logic [DW-2:0] PROCESS_NOISE_RST = (DW-1)'(655);
  localparam logic [DW-2:0] MEASURE_NOISE_RST = (DW-1)'(65536);
  localparam fix_t          VARIANCE_RST      = fix_t'({1'b0, PROCESS_NOISE_RST});

  typedef enum logic [1:0] {
    REG_STATE_GAIN,
    REG_OBSERVE_GAIN,
    REG_PROCESS_NOISE,
    REG_MEASURE_NOISE
  } cfg_idx_t;

  typedef enum logic {
    CMD_FILTER,
    CMD_CLEAR
  } cmd_t;

  // Sequencer steps, one per cycle but for the divider wait and output stall
  typedef enum logic [4:0] {
    ST_IDLE,
    ST_A2,  // issue a*a
    ST_H2,  // take a^2, issue h*h
    ST_PX,  // take h^2, issue a*x
    ST_PP,  // take x, issue a^2*p
    ST_PQ,  // take a^2*p
    ST_PV,  // p = a^2*p + q
    ST_DM,  // issue h^2*p
    ST_DT,  // take h^2*p
    ST_DA,  // den = h^2*p + r
    ST_DC,  // check den, issue p*h
    ST_NT,  // take numerator
    ST_DV,  // start divider
    ST_DW,  // wait for gain
    ST_IM,  // issue h*x
    ST_IT,  // take h*x
    ST_IS,  // innovation z - h*x
    ST_KM,  // issue k*innovation
    ST_KT,  // take correction
    ST_KA,  // x += correction
    ST_GM,  // issue k*h
    ST_GT,  // take k*h
    ST_GS,  // 1 - k*h
    ST_VM,  // issue (1-k*h)*p
    ST_VT,  // take p, issue h*x
    ST_OT   // take h*x into output register
  } state_t;

  typedef struct packed {
    fix_t mul_a;
    fix_t mul_b;
    fix_t add_a;
    fix_t add_b;
    logic sub;
  } alu_req_t;

  typedef struct packed {
    fix_t mul_res;
    logic mul_clip;
    fix_t add_res;
    logic add_clip;
  } alu_rsp_t;

  typedef struct packed {
    logic          start;
    fix_t          num;
    logic [DW-2:0] den;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
    fix_t quot;
    logic clip;
  } div_rsp_t;

endpackage

`default_nettype wire

FILE: hw/rtl/skf_in_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface skf_in_if;
  import skf_pkg::*;

  logic valid;
  logic ready;
  cmd_t cmd;
  fix_t sample;

  modport source (output valid, output cmd, output sample, input ready);
  modport sink   (input valid, input cmd, input sample, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/skf_out_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface skf_out_if;
  import skf_pkg::*;

  logic valid;
  logic ready;
  fix_t filtered;
  logic saturated;

  modport source (output valid, output filtered, output saturated, input ready);
  modport sink   (input valid, input filtered, input saturated, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/skf_cfg_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface skf_cfg_if;
  import skf_pkg::*;

  logic          valid;
  logic          ready;
  cfg_idx_t      index;
  logic [DW-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/skf_alu.sv
`timescale 1ns / 1ps
`default_nettype none

// Shared arithmetic: registered magnitude multiplier with round and
// saturate on the following cycle, plus a saturating add/subtract.
module skf_alu (
  input  logic               clk,
  input  skf_pkg::alu_req_t  req,
  output skf_pkg::alu_rsp_t  rsp
);
  import skf_pkg::*;

  localparam int PW   = 2 * DW;
  localparam int RQ_W = PW - FW;

  logic [DW-1:0]   mag_a;
  logic [DW-1:0]   mag_b;
  logic [PW-1:0]   prod;
  logic            neg;
  logic [PW-1:0]   rnd;
  logic [RQ_W-1:0] rq;
  logic            over_p;
  logic            over_n;
  logic [DW:0]     ext_a;
  logic [DW:0]     ext_b;
  logic [DW:0]     sum;

  // Operand magnitudes; the minimum value maps to 2^(DW-1)
  assign mag_a = req.mul_a[DW-1] ? (~req.mul_a + DW'(1)) : req.mul_a;
  assign mag_b = req.mul_b[DW-1] ? (~req.mul_b + DW'(1)) : req.mul_b;

  // Product stage
  always_ff @(posedge clk) begin
    prod <= PW'(mag_a) * PW'(mag_b);
    neg  <= req.mul_a[DW-1] ^ req.mul_b[DW-1];
  end

  // Round half away from zero on the magnitude, then drop fraction bits
  assign rnd = prod + (PW'(1) << (FW - 1));
  assign rq  = rnd[PW-1:FW];

  // Positive side tops out at 2^(DW-1)-1, negative side at 2^(DW-1)
  assign over_p = |rq[RQ_W-1:DW-1];
  assign over_n = (|rq[RQ_W-1:DW]) | (rq[DW-1] & (|rq[DW-2:0]));

  // Saturating sum or difference, exact in DW+1 bits
  assign ext_a = {req.add_a[DW-1], req.add_a};
  assign ext_b = {req.add_b[DW-1], req.add_b};
  assign sum   = req.sub ? (ext_a - ext_b) : (ext_a + ext_b);

  always_comb begin
    if (neg) begin
      rsp.mul_clip = over_n;
      rsp.mul_res  = over_n ? FIX_MIN : fix_t'(~rq[DW-1:0] + DW'(1));
    end else begin
      rsp.mul_clip = over_p;
      rsp.mul_res  = over_p ? FIX_MAX : fix_t'(rq[DW-1:0]);
    end
    rsp.add_clip = sum[DW] ^ sum[DW-1];
    if (rsp.add_clip) begin
      rsp.add_res = sum[DW] ? FIX_MIN : FIX_MAX;
    end else begin
      rsp.add_res = fix_t'(sum[DW-1:0]);
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/skf_div.sv
`timescale 1ns / 1ps
`default_nettype none

// Restoring divider for the gain: |num| * 2^FW / den, one quotient bit
// per cycle, sign applied and saturated on the way out.
module skf_div (
  input  logic               clk,
  input  logic               rst,
  input  skf_pkg::div_req_t  req,
  output skf_pkg::div_rsp_t  rsp
);
  import skf_pkg::*;

  logic                 busy;
  logic                 done;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DW-2:0]        rem;
  logic [DW-2:0]        den;
  logic [DIV_W-1:0]     sh;
  logic                 neg;
  logic [DW-1:0]        mag;
  logic [DW-1:0]        trial;
  logic [DW-1:0]        diff;
  logic                 qbit;
  logic                 over_p;
  logic                 over_n;

  assign mag = req.num[DW-1] ? (~req.num + DW'(1)) : req.num;

  // One shift-subtract step
  assign trial = {rem, sh[DIV_W-1]};
  assign diff  = trial - DW'(den);
  assign qbit  = trial >= DW'(den);

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
      end else if (busy && cnt == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // Datapath; dividend shifts out as quotient bits shift in
  always_ff @(posedge clk) begin
    if (req.start) begin
      cnt <= DIV_LAST;
      rem <= '0;
      den <= req.den;
      sh  <= {mag, FW'(0)};
      neg <= req.num[DW-1];
    end else if (busy) begin
      cnt <= cnt - DIV_CNT_W'(1);
      rem <= qbit ? diff[DW-2:0] : trial[DW-2:0];
      sh  <= {sh[DIV_W-2:0], qbit};
    end
  end

  assign over_p = |sh[DIV_W-1:DW-1];
  assign over_n = (|sh[DIV_W-1:DW]) | (sh[DW-1] & (|sh[DW-2:0]));

  always_comb begin
    rsp.busy = busy;
    rsp.done = done;
    if (neg) begin
      rsp.clip = over_n;
      rsp.quot = over_n ? FIX_MIN : fix_t'(~sh[DW-1:0] + DW'(1));
    end else begin
      rsp.clip = over_p;
      rsp.quot = over_p ? FIX_MAX : fix_t'(sh[DW-1:0]);
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/scalar_kalman_filter_top.sv
// Channel  Dir  Payload                        Accepted when
// meas     in   cmd, sample (Q16.16)           meas.valid && meas.ready
// result   out  filtered (Q16.16), saturated   result.valid && result.ready
// cfg      in   index, data                    cfg.valid && cfg.ready
//
// A sample runs the whole sequence to its result before the next item is
// taken, in idle; the gain comes from the one-bit-per-cycle divider. When the
// gain denominator is not positive the divider is skipped.
// A clear is taken in idle, leaves the sequencer idle and gives no result.
// rst is synchronous; variance restarts at the process noise reset value.
// A result waits in the output register; the next sample may run meanwhile
// and holds in its last step only if the older result is still untaken.
`timescale 1ns / 1ps
`default_nettype none
`include "scalar_kalman_filter_top_defines.svh"

module scalar_kalman_filter_top (
  input  logic       clk,
  input  logic       rst,
  skf_in_if.sink     meas,
  skf_out_if.source  result,
  skf_cfg_if.sink    cfg
);
  import skf_pkg::*;

  state_t        state, state_next;
  logic          primed, primed_next;
  logic          out_valid, out_valid_next;
  fix_t          estimate, estimate_next;
  fix_t          variance, variance_next;
  fix_t          a2, a2_next;
  fix_t          h2, h2_next;
  fix_t          t, t_next;
  fix_t          den, den_next;
  fix_t          k, k_next;
  fix_t          z, z_next;
  logic          clip, clip_next;
  fix_t          out_filtered, out_filtered_next;
  logic          out_saturated, out_saturated_next;

  fix_t          state_gain;
  fix_t          observe_gain;
  logic [DW-2:0] process_noise;
  logic [DW-2:0] measure_noise;

  alu_req_t      alu_req;
  alu_rsp_t      alu_rsp;
  div_req_t      div_req;
  div_rsp_t      div_rsp;

  skf_alu u_alu (
    .clk (clk),
    .req (alu_req),
    .rsp (alu_rsp)
  );

  skf_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // Handshakes
  assign meas.ready       = (state == ST_IDLE);
  assign cfg.ready        = 1'b1;
  assign result.valid     = out_valid;
  assign result.filtered  = out_filtered;
  assign result.saturated = out_saturated;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state_gain    <= STATE_GAIN_RST;
      observe_gain  <= OBSERVE_GAIN_RST;
      process_noise <= PROCESS_NOISE_RST;
      measure_noise <= MEASURE_NOISE_RST;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        REG_STATE_GAIN:    state_gain    <= fix_t'(cfg.data);
        REG_OBSERVE_GAIN:  observe_gain  <= fix_t'(cfg.data);
        REG_PROCESS_NOISE: process_noise <= cfg.data[DW-2:0];
        REG_MEASURE_NOISE: measure_noise <= cfg.data[DW-2:0];
        default: ;
      endcase
    end
  end

  // Sequencer: next state, operand routing and register updates
  always_comb begin
    state_next         = state;
    primed_next        = primed;
    out_valid_next     = out_valid & ~result.ready;
    estimate_next      = estimate;
    variance_next      = variance;
    a2_next            = a2;
    h2_next            = h2;
    t_next             = t;
    den_next           = den;
    k_next             = k;
    z_next             = z;
    clip_next          = clip;
    out_filtered_next  = out_filtered;
    out_saturated_next = out_saturated;
    alu_req            = '0;
    div_req            = '0;

    case (state)
      ST_IDLE: begin
        if (meas.valid) begin
          if (meas.cmd == CMD_CLEAR) begin
            primed_next = 1'b0;
          end else begin
            z_next      = meas.sample;
            clip_next   = 1'b0;
            primed_next = 1'b1;
            if (!primed) begin
              estimate_next = meas.sample;
            end
            state_next = ST_A2;
          end
        end
      end
      ST_A2: begin
        alu_req.mul_a = state_gain;
        alu_req.mul_b = state_gain;
        state_next    = ST_H2;
      end
      ST_H2: begin
        a2_next       = alu_rsp.mul_res;
        clip_next     = clip | alu_rsp.mul_clip;
        alu_req.mul_a = observe_gain;
        alu_req.mul_b = observe_gain;
        state_next    = ST_PX;
      end
      ST_PX: begin
        h2_next       = alu_rsp.mul_res;
        clip_next     = clip | alu_rsp.mul_clip;
        alu_req.mul_a = state_gain;
        alu_req.mul_b = estimate;
        state_next    = ST_PP;
      end
      ST_PP: begin
        estimate_next = alu_rsp.mul_res;
        clip_next     = clip | alu_rsp.mul_clip;
        alu_req.mul_a = a2;
        alu_req.mul_b = variance;
        state_next    = ST_PQ;
      end
      ST_PQ: begin
        t_next     = alu_rsp.mul_res;
        clip_next  = clip | alu_rsp.mul_clip;
        state_next = ST_PV;
      end
      ST_PV: begin
        alu_req.add_a = t;
        alu_req.add_b = fix_t'({1'b0, process_noise});
        variance_next = alu_rsp.add_res;
        clip_next     = clip | alu_rsp.add_clip;
        state_next    = ST_DM;
      end
      ST_DM: begin
        alu_req.mul_a = h2;
        alu_req.mul_b = variance;
        state_next    = ST_DT;
      end
      ST_DT: begin
        t_next     = alu_rsp.mul_res;
        clip_next  = clip | alu_rsp.mul_clip;
        state_next = ST_DA;
      end
      ST_DA: begin
        alu_req.add_a = t;
        alu_req.add_b = fix_t'({1'b0, measure_noise});
        den_next      = alu_rsp.add_res;
        clip_next     = clip | alu_rsp.add_clip;
        state_next    = ST_DC;
      end
      ST_DC: begin
        // Non-positive denominator: zero gain, flagged
        if (den[DW-1] || den == '0) begin
          k_next     = '0;
          clip_next  = 1'b1;
          state_next = ST_IM;
        end else begin
          alu_req.mul_a = variance;
          alu_req.mul_b = observe_gain;
          state_next    = ST_NT;
        end
      end
      ST_NT: begin
        t_next     = alu_rsp.mul_res;
        clip_next  = clip | alu_rsp.mul_clip;
        state_next = ST_DV;
      end
      ST_DV: begin
        div_req.start = 1'b1;
        div_req.num   = t;
        div_req.den   = den[DW-2:0];
        state_next    = ST_DW;
      end
      ST_DW: begin
        if (div_rsp.done) begin
          k_next     = div_rsp.quot;
          clip_next  = clip | div_rsp.clip;
          state_next = ST_IM;
        end
      end
      ST_IM: begin
        alu_req.mul_a = observe_gain;
        alu_req.mul_b = estimate;
        state_next    = ST_IT;
      end
      ST_IT: begin
        t_next     = alu_rsp.mul_res;
        clip_next  = clip | alu_rsp.mul_clip;
        state_next = ST_IS;
      end
      ST_IS: begin
        alu_req.add_a = z;
        alu_req.add_b = t;
        alu_req.sub   = 1'b1;
        t_next        = alu_rsp.add_res;
        clip_next     = clip | alu_rsp.add_clip;
        state_next    = ST_KM;
      end
      ST_KM: begin
        alu_req.mul_a = k;
        alu_req.mul_b = t;
        state_next    = ST_KT;
      end
      ST_KT: begin
        t_next     = alu_rsp.mul_res;
        clip_next  = clip | alu_rsp.mul_clip;
        state_next = ST_KA;
      end
      ST_KA: begin
        alu_req.add_a = estimate;
        alu_req.add_b = t;
        estimate_next = alu_rsp.add_res;
        clip_next     = clip | alu_rsp.add_clip;
        state_next    = ST_GM;
      end
      ST_GM: begin
        alu_req.mul_a = k;
        alu_req.mul_b = observe_gain;
        state_next    = ST_GT;
      end
      ST_GT: begin
        t_next     = alu_rsp.mul_res;
        clip_next  = clip | alu_rsp.mul_clip;
        state_next = ST_GS;
      end
      ST_GS: begin
        alu_req.add_a = FIX_ONE;
        alu_req.add_b = t;
        alu_req.sub   = 1'b1;
        t_next        = alu_rsp.add_res;
        clip_next     = clip | alu_rsp.add_clip;
        state_next    = ST_VM;
      end
      ST_VM: begin
        alu_req.mul_a = t;
        alu_req.mul_b = variance;
        state_next    = ST_VT;
      end
      ST_VT: begin
        variance_next = alu_rsp.mul_res;
        clip_next     = clip | alu_rsp.mul_clip;
        alu_req.mul_a = observe_gain;
        alu_req.mul_b = estimate;
        state_next    = ST_OT;
      end
      ST_OT: begin
        // Keep operands up so the product holds while the output is busy
        alu_req.mul_a = observe_gain;
        alu_req.mul_b = estimate;
        if (!out_valid || result.ready) begin
          out_filtered_next  = alu_rsp.mul_res;
          out_saturated_next = clip | alu_rsp.mul_clip;
          out_valid_next     = 1'b1;
          state_next         = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Control and filter state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      primed    <= 1'b0;
      out_valid <= 1'b0;
      estimate  <= '0;
      variance  <= VARIANCE_RST;
    end else begin
      state     <= state_next;
      primed    <= primed_next;
      out_valid <= out_valid_next;
      estimate  <= estimate_next;
      variance  <= variance_next;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    a2            <= a2_next;
    h2            <= h2_next;
    t             <= t_next;
    den           <= den_next;
    k             <= k_next;
    z             <= z_next;
    clip          <= clip_next;
    out_filtered  <= out_filtered_next;
    out_saturated <= out_saturated_next;
  end

  // Checks
  `SKF_ASSERT_NEXT(a_sample_primes, clk, rst, meas.valid && meas.ready && meas.cmd == CMD_FILTER, primed)
  `SKF_ASSERT_NEXT(a_clear_unprimes, clk, rst, meas.valid && meas.ready && meas.cmd == CMD_CLEAR, !primed)
  `SKF_ASSERT_IMPL(a_result_from_last_step, clk, rst, $rose(out_valid), $past(state) == ST_OT)
  `SKF_ASSERT_IMPL(a_div_start_idle, clk, rst, div_req.start, !div_rsp.busy)
  `SKF_ASSERT_IMPL(a_wait_has_div, clk, rst, state == ST_DW, div_rsp.busy || div_rsp.done)

endmodule

`default_nettype wire

FILE: sim/tb.sv
`timescale 1ns / 1ps

module tb;
  import skf_pkg::*;

  localparam int DIR_ROWS        = 25;
  localparam int NUM_PHASES      = 8;
  localparam int ITEMS_PER_PHASE = 54;
  localparam int DRAIN_CYCLES    = 80;    // one full sample plus margin
  localparam int HOLD_CYCLES     = 400;
  localparam int QUIET_LIMIT     = 3000;

  localparam longint WORD_MAX = longint'(FIX_MAX);
  localparam longint WORD_MIN = longint'(FIX_MIN);
  localparam longint WORD_ONE = longint'(FIX_ONE);

  typedef struct packed {
    fix_t filtered;
    logic saturated;
  } filt_res_t;

  typedef enum logic {
    ROW_ITEM,
    ROW_CFG
  } row_kind_t;

  typedef struct packed {
    row_kind_t     kind;
    cmd_t          cmd;
    fix_t          sample;
    logic          typed;
    fix_t          exp_filtered;
    logic          exp_saturated;
    logic [DW-1:0] a_val;
    logic [DW-1:0] h_val;
    logic [DW-1:0] q_val;
    logic [DW-1:0] r_val;
  } dir_row_t;

  logic clk;
  logic rst;

  skf_in_if  meas_if ();
  skf_out_if res_if ();
  skf_cfg_if cfg_if ();

  scalar_kalman_filter_top u_top (
    .clk    (clk),
    .rst    (rst),
    .meas   (meas_if),
    .result (res_if),
    .cfg    (cfg_if)
  );

  // Filter model state and register copies
  longint kf_a      = longint'(STATE_GAIN_RST);
  longint kf_h      = longint'(OBSERVE_GAIN_RST);
  longint kf_q      = longint'(PROCESS_NOISE_RST);
  longint kf_r      = longint'(MEASURE_NOISE_RST);
  longint kf_est    = 0;
  longint kf_var    = longint'(VARIANCE_RST);
  bit     kf_primed = 1'b0;
  bit     clip_hit;

  filt_res_t filtered_q[$];
  int        err_cnt  = 0;
  bit        idling   = 1'b1;
  bit        hold_req = 1'b0;
  bit        row_typed = 1'b0;
  filt_res_t row_exp;
  dir_row_t  dir_tbl [DIR_ROWS];

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Fixed-point arithmetic of the filter
  // ---------------------------------------------------------------------------

  function automatic longint clamp32(input longint v);
    if (v > WORD_MAX) begin
      clip_hit = 1'b1;
      return WORD_MAX;
    end
    if (v < WORD_MIN) begin
      clip_hit = 1'b1;
      return WORD_MIN;
    end
    return v;
  endfunction

  // Signed value from sign and magnitude, clipped to the word range
  function automatic longint from_mag(input bit neg, input bit [63:0] mag);
    if (!neg) begin
      if (mag > 64'h7FFF_FFFF) begin
        clip_hit = 1'b1;
        return WORD_MAX;
      end
      return longint'(mag);
    end
    if (mag > 64'h8000_0000) begin
      clip_hit = 1'b1;
      return WORD_MIN;
    end
    return -longint'(mag);
  endfunction

  // Q16.16 product, rounded half away from zero
  function automatic longint qmul(input longint x, input longint y);
    bit [63:0] mx;
    bit [63:0] my;
    bit [63:0] prod;
    mx   = (x < 0) ? 64'(-x) : 64'(x);
    my   = (y < 0) ? 64'(-y) : 64'(y);
    prod = (mx * my + (64'd1 << (FW - 1))) >> FW;
    return from_mag((x < 0) != (y < 0), prod);
  endfunction

  // Q16.16 quotient truncated toward zero; den is positive
  function automatic longint qdiv(input longint num, input longint den);
    bit [63:0] mag;
    mag = (num < 0) ? 64'(-num) : 64'(num);
    return from_mag(num < 0, (mag << FW) / 64'(den));
  endfunction

  // One sample through predict, gain and correct
  function automatic filt_res_t predict_sample(input fix_t z);
    longint    a2;
    longint    h2;
    longint    den;
    longint    k;
    longint    zl;
    filt_res_t res;
    clip_hit = 1'b0;
    zl = longint'(z);
    a2 = qmul(kf_a, kf_a);
    h2 = qmul(kf_h, kf_h);
    if (!kf_primed) begin
      kf_est    = zl;
      kf_primed = 1'b1;
    end
    kf_est = qmul(kf_a, kf_est);
    kf_var = clamp32(qmul(a2, kf_var) + kf_q);
    den = clamp32(qmul(h2, kf_var) + kf_r);
    if (den <= 0) begin
      // gain forced to zero when the denominator is not positive
      clip_hit = 1'b1;
      k = 0;
    end else begin
      k = qdiv(qmul(kf_var, kf_h), den);
    end
    kf_est = clamp32(kf_est + qmul(k, clamp32(zl - qmul(kf_h, kf_est))));
    kf_var = qmul(clamp32(WORD_ONE - qmul(k, kf_h)), kf_var);
    res.filtered  = fix_t'(qmul(kf_h, kf_est));
    res.saturated = clip_hit;
    return res;
  endfunction

  function automatic void flag_error(input string msg);
    err_cnt++;
    if (err_cnt <= 10) $display("ERROR @%0t: %s", $time, msg);
  endfunction

  // ---------------------------------------------------------------------------
  // Monitors
  // ---------------------------------------------------------------------------

  // Register writes update the model copies
  always @(posedge clk) begin
    if (cfg_if.valid && cfg_if.ready) begin
      case (cfg_if.index)
        REG_STATE_GAIN:    kf_a = longint'(fix_t'(cfg_if.data));
        REG_OBSERVE_GAIN:  kf_h = longint'(fix_t'(cfg_if.data));
        REG_PROCESS_NOISE: kf_q = longint'(cfg_if.data[DW-2:0]);
        REG_MEASURE_NOISE: kf_r = longint'(cfg_if.data[DW-2:0]);
        default: ;
      endcase
    end
  end

  // Accepted items: clear unprimes, a sample queues its expected result
  always @(posedge clk) begin : meas_mon
    filt_res_t pred;
    if (meas_if.valid && meas_if.ready) begin
      if (meas_if.cmd == CMD_CLEAR) begin
        kf_primed = 1'b0;
      end else begin
        pred = predict_sample(meas_if.sample);
        filtered_q.push_back(row_typed ? row_exp : pred);
      end
    end
  end

  // Results against the oldest expectation
  always @(posedge clk) begin : result_mon
    filt_res_t want;
    if (res_if.valid && res_if.ready) begin
      if (filtered_q.size() == 0) begin
        flag_error($sformatf("unexpected result filtered=%h saturated=%b",
                             res_if.filtered, res_if.saturated));
      end else begin
        want = filtered_q.pop_front();
        if (res_if.filtered !== want.filtered)
          flag_error($sformatf("filtered mismatch: exp %h got %h",
                               want.filtered, res_if.filtered));
        if (res_if.saturated !== want.saturated)
          flag_error($sformatf("saturated mismatch: exp %b got %b",
                               want.saturated, res_if.saturated));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result side ready: random stall bursts, one long hold-off on request
  // ---------------------------------------------------------------------------

  initial begin
    res_if.ready = 1'b0;
    @(negedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        res_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else if (idling && $urandom_range(0, 5) == 0) begin
        res_if.ready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(negedge clk);
      end else begin
        res_if.ready <= 1'b1;
        @(negedge clk);
      end
    end
  end

  // Watchdog on cycles with no handshake on any channel
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((meas_if.valid && meas_if.ready) || (res_if.valid && res_if.ready) ||
          (cfg_if.valid && cfg_if.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("TEST FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic dir_row_t item_row(input cmd_t c, input fix_t s, input logic t,
                                        input fix_t f, input logic sat);
    dir_row_t row;
    row               = '0;
    row.kind          = ROW_ITEM;
    row.cmd           = c;
    row.sample        = s;
    row.typed         = t;
    row.exp_filtered  = f;
    row.exp_saturated = sat;
    return row;
  endfunction

  function automatic dir_row_t cfg_row(input logic [DW-1:0] a, input logic [DW-1:0] h,
                                       input logic [DW-1:0] q, input logic [DW-1:0] r);
    dir_row_t row;
    row       = '0;
    row.kind  = ROW_CFG;
    row.cmd   = CMD_FILTER;
    row.a_val = a;
    row.h_val = h;
    row.q_val = q;
    row.r_val = r;
    return row;
  endfunction

  function automatic logic [DW-1:0] edge_val();
    case ($urandom_range(0, 5))
      0:       return FIX_MAX;
      1:       return FIX_MIN;
      2:       return '0;
      3:       return FIX_ONE;
      4:       return -FIX_ONE;
      default: return 32'd1;
    endcase
  endfunction

  // Offer one item; called and returns at a falling edge, valid high but for idle gaps
  task automatic put_item(input cmd_t c, input fix_t s);
    meas_if.valid  <= 1'b1;
    meas_if.cmd    <= c;
    meas_if.sample <= s;
    @(posedge clk);
    while (!meas_if.ready) @(posedge clk);
    @(negedge clk);
    if (idling && $urandom_range(0, 3) == 0) begin
      meas_if.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
  endtask

  // Stop offering and let the block go idle
  task automatic settle();
    meas_if.valid <= 1'b0;
    do @(negedge clk); while (filtered_q.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_regs(input logic [DW-1:0] a, input logic [DW-1:0] h,
                            input logic [DW-1:0] q, input logic [DW-1:0] r);
    logic [DW-1:0] vals [4];
    vals = '{a, h, q, r};
    for (int i = 0; i < 4; i++) begin
      cfg_if.valid <= 1'b1;
      cfg_if.index <= cfg_idx_t'(i);
      cfg_if.data  <= vals[i];
      @(posedge clk);
      while (!cfg_if.ready) @(posedge clk);
      @(negedge clk);
    end
    cfg_if.valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------

  initial begin : stimulus
    int            mode;
    int            trk;
    cmd_t          c;
    fix_t          s;
    logic [DW-1:0] ra;
    logic [DW-1:0] rh;
    logic [DW-1:0] rq;
    logic [DW-1:0] rr;

    rst            = 1'b1;
    meas_if.valid  = 1'b0;
    meas_if.cmd    = CMD_FILTER;
    meas_if.sample = '0;
    cfg_if.valid   = 1'b0;
    cfg_if.index   = REG_STATE_GAIN;
    cfg_if.data    = '0;
    row_exp        = '0;
    trk            = 0;

    dir_tbl = '{
      // zero sample right after reset stays zero
      item_row(CMD_FILTER, '0, 1'b1, '0, 1'b0),
      item_row(CMD_FILTER, 32'h0001_8000, 1'b0, '0, 1'b0),
      item_row(CMD_FILTER, FIX_MAX, 1'b0, '0, 1'b0),
      item_row(CMD_CLEAR, 32'h1234_5678, 1'b0, '0, 1'b0),
      item_row(CMD_FILTER, FIX_MIN, 1'b0, '0, 1'b0),
      // all gains and noises zero: denominator zero, gain zero
      cfg_row('0, '0, '0, '0),
      item_row(CMD_FILTER, FIX_MAX, 1'b1, '0, 1'b1),
      // unit gains, zero noise: estimate passes through, denominator still zero
      cfg_row(FIX_ONE, FIX_ONE, '0, '0),
      item_row(CMD_CLEAR, '0, 1'b0, '0, 1'b0),
      item_row(CMD_FILTER, FIX_MAX, 1'b1, FIX_MAX, 1'b1),
      item_row(CMD_CLEAR, '1, 1'b0, '0, 1'b0),
      item_row(CMD_FILTER, FIX_MIN, 1'b1, FIX_MIN, 1'b1),
      // register extremes, products overflow
      cfg_row(FIX_MAX, FIX_MIN, 32'h7FFF_FFFF, 32'h7FFF_FFFF),
      item_row(CMD_FILTER, FIX_MAX, 1'b0, '0, 1'b0),
      item_row(CMD_FILTER, FIX_MIN, 1'b0, '0, 1'b0),
      item_row(CMD_FILTER, 32'd1, 1'b0, '0, 1'b0),
      cfg_row(FIX_MIN, FIX_MAX, 32'd1, 32'd1),
      item_row(CMD_CLEAR, '0, 1'b0, '0, 1'b0),
      item_row(CMD_FILTER, -32'sd1, 1'b0, '0, 1'b0),
      item_row(CMD_FILTER, 32'h0000_8000, 1'b0, '0, 1'b0),
      // negative transition, top bit of the noise write is dropped
      cfg_row(-FIX_ONE, 32'h0000_8000, 32'h8000_028F, 32'h0004_0000),
      item_row(CMD_CLEAR, '0, 1'b0, '0, 1'b0),
      item_row(CMD_FILTER, 32'h0010_0000, 1'b0, '0, 1'b0),
      item_row(CMD_FILTER, 32'hFFF0_0000, 1'b0, '0, 1'b0),
      item_row(CMD_FILTER, 32'h0010_8000, 1'b0, '0, 1'b0)
    };

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed rows
    for (int i = 0; i < DIR_ROWS; i++) begin
      if (dir_tbl[i].kind == ROW_CFG) begin
        settle();
        write_regs(dir_tbl[i].a_val, dir_tbl[i].h_val, dir_tbl[i].q_val, dir_tbl[i].r_val);
      end else begin
        row_typed         = dir_tbl[i].typed;
        row_exp.filtered  = dir_tbl[i].exp_filtered;
        row_exp.saturated = dir_tbl[i].exp_saturated;
        put_item(dir_tbl[i].cmd, dir_tbl[i].sample);
      end
    end
    row_typed = 1'b0;

    // Random phases: tracking, wild and edge register settings
    for (int p = 0; p < NUM_PHASES; p++) begin
      mode   = (p == NUM_PHASES - 1) ? 0 : p % 3;
      settle();
      idling = (p != 3) && (p != NUM_PHASES - 1);
      case (mode)
        0: begin
          ra = $urandom_range(57344, 73728);
          rh = $urandom_range(16384, 196608);
          if ($urandom_range(0, 1) == 1) rh = -rh;
          rq = $urandom_range(0, 16384);
          rr = $urandom_range(1024, 4194304);
        end
        1: begin
          ra = $urandom;
          rh = $urandom;
          rq = $urandom;
          rr = $urandom;
        end
        default: begin
          ra = edge_val();
          rh = edge_val();
          rq = edge_val();
          rr = edge_val();
        end
      endcase
      write_regs(ra, rh, rq, rr);

      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        // long result hold-off while items keep coming
        if (p == 1 && n == 10) hold_req = 1'b1;
        // pause until every queued result is out
        if (p == 2 && n == 20) begin
          meas_if.valid <= 1'b0;
          do @(negedge clk); while (filtered_q.size() != 0);
        end
        c = ($urandom_range(0, 9) == 0) ? CMD_CLEAR : CMD_FILTER;
        if (mode == 0 && $urandom_range(0, 4) != 0) begin
          trk += int'($urandom_range(0, 131072)) - 65536;
          if (trk > (1 << 26) || trk < -(1 << 26)) trk = 0;
          s = trk + int'($urandom_range(0, 65536)) - 32768;
        end else begin
          s = $urandom;
        end
        put_item(c, s);
      end
    end

    // Drain and report
    meas_if.valid <= 1'b0;
    do @(negedge clk); while (filtered_q.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
